>>> design/wrfs_pkg.sv
// Shared types, constants and helpers of the windowed RGB565 frame store.
package wrfs_pkg;

  localparam int unsigned ScreenWDefault = 320;
  localparam int unsigned ScreenHDefault = 240;

  typedef enum logic [2:0] {
    REQ_WINDOW = 3'd0,
    REQ_FILL   = 3'd1,
    REQ_TEXT   = 3'd2,
    REQ_GLYPH  = 3'd3,
    REQ_SAMPLE = 3'd4,
    REQ_READ   = 3'd5
  } req_e;

  function automatic logic [15:0] to565(input logic [23:0] rgb);
    to565 = {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

endpackage

>>> design/wrfs_ram.sv
// Generic single-port synchronous RAM with registered read.
module wrfs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 76800,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> design/windowed_rgb565_frame_store.sv
// Top level of the windowed RGB565 frame store with its request sequencer.
//
// One request channel (req_valid_i / req_stall_o, one port per field) and one
// result channel (rsp_valid_o / rsp_stall_i). Only a read request yields a
// result; all other kinds update the store or its window and glyph state.
//
// After reset the block sweeps the whole pixel memory (SCREEN_W*SCREEN_H
// pixels, 76800 at the default size) to zero, one pixel per cycle, with
// req_stall_o high meanwhile.
//
// Window, glyph start, glyph sample and unused kinds are done in idle when
// taken. A fill writes its clipped pixels row by row in the fill state; a
// text strip steps its cursor (scale*scale*8 steps at most, none for scale
// zero) in the text state, and when the window runs out before the strip
// ends, that state notices it and returns to idle. The single memory port
// writes one pixel a cycle. A read sends its address when taken; the read
// state then registers the memory data as the result; requests stall meanwhile.
//
// The result register holds its transfer while rsp_stall_i is high; the next
// request is taken meanwhile, only a second read waits until the register
// frees.
module windowed_rgb565_frame_store
  import wrfs_pkg::*;
#(
  parameter int unsigned SCREEN_W = ScreenWDefault,
  parameter int unsigned SCREEN_H = ScreenHDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] size_w_i,
  input  logic signed [15:0] size_h_i,
  input  logic [23:0] color_a_i,
  input  logic [23:0] color_b_i,
  input  logic [7:0]  font_bits_i,
  input  logic [7:0]  scale_i,
  input  logic [7:0]  gray_i,
  input  logic [7:0]  threshold_i,
  output logic        rsp_valid_o,
  input  logic        rsp_stall_i,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_red_o,
  output logic        in_range_o
);

  localparam int unsigned Depth = SCREEN_W * SCREEN_H;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FILL, ST_TEXT, ST_READ
  } state_e;

  state_e state_q;

  // Coordinates live in 18-bit signed so sums of two 16-bit values never wrap.
  logic signed [17:0] win_x_q, win_y_q, win_w_q, win_h_q, cur_x_q, cur_y_q;
  logic signed [17:0] gx_q, gy_q, gw_q, gh_q, gcol_q, grow_q;
  logic [7:0]  glevel_q;
  logic [15:0] gfore_q, gback_q;

  // Fill sweep: current x/y and clipped bounds.
  logic signed [17:0] fx_q, fy_q, fx0_q, fx1_q, fy1_q;
  logic [15:0] color_q, color2_q;

  // Text strip counters.
  logic [7:0]  row_q, scale_q, sv_q, sc_q;
  logic [2:0]  bit_q;

  logic [AddrW-1:0] clr_q;
  logic [AddrW-1:0] rowbase_q;   // fy*SCREEN_W during fills

  // Read result.
  logic        rd_in_q, rsp_valid_q;
  logic [15:0] rd_data_q;

  logic             we;
  logic [AddrW-1:0] addr;
  logic [15:0]      wdata, rdata;

  wrfs_ram #(.Width(16), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  localparam logic signed [17:0] SW = 18'(SCREEN_W);
  localparam logic signed [17:0] SH = 18'(SCREEN_H);

  function automatic logic on_screen(input logic signed [17:0] x,
                                     input logic signed [17:0] y);
    on_screen = (x >= 0) && (y >= 0) && (x < SW) && (y < SH);
  endfunction

  function automatic logic [AddrW-1:0] pix_addr(input logic signed [17:0] x,
                                                input logic signed [17:0] y);
    logic [31:0] p;
    p = 32'(y[12:0]) * 32'(SCREEN_W) + 32'(x[12:0]);
    pix_addr = p[AddrW-1:0];
  endfunction

  logic accept;
  assign accept = req_valid_i && !req_stall_o;
  assign req_stall_o = (state_q != ST_IDLE) ||
                       (req_type_i == REQ_READ && rsp_valid_q && rsp_stall_i);

  logic signed [17:0] px, py, sw, sh;
  assign px = 18'(pos_x_i);
  assign py = 18'(pos_y_i);
  assign sw = 18'(size_w_i);
  assign sh = 18'(size_h_i);

  // Window pixel in text state.
  logic win_ok, samp_ok, samp_fg;
  logic signed [17:0] wpx, wpy, spx, spy;
  assign win_ok  = (win_w_q > 0) && (win_h_q > 0) && (cur_y_q < win_h_q);
  assign wpx     = win_x_q + cur_x_q;
  assign wpy     = win_y_q + cur_y_q;
  assign samp_ok = (gw_q > 0) && (gh_q > 0) && (grow_q < gh_q);
  assign spx     = gx_q + gcol_q;
  assign spy     = gy_q + grow_q;
  assign samp_fg = gray_i >= glevel_q;

  // Memory port: address and write selection.
  always_comb begin
    we    = 1'b0;
    addr  = clr_q;
    wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_FILL: begin
        we    = 1'b1;
        addr  = rowbase_q + AddrW'(fx_q[12:0]);
        wdata = color_q;
      end
      ST_TEXT: begin
        we    = win_ok && on_screen(wpx, wpy);
        addr  = pix_addr(wpx, wpy);
        wdata = row_q[bit_q] ? color_q : color2_q;
      end
      ST_IDLE: begin
        if (accept && req_type_i == REQ_SAMPLE) begin
          we    = samp_ok && on_screen(spx, spy);
          addr  = pix_addr(spx, spy);
          wdata = samp_fg ? gfore_q : gback_q;
        end else if (accept && req_type_i == REQ_READ) begin
          addr = pix_addr(px, py);
        end
      end
      default: ;
    endcase
  end

  // Fill clip bounds.
  logic signed [17:0] cx0, cy0, cx1, cy1;
  always_comb begin
    cx0 = (px < 0) ? '0 : px;
    cy0 = (py < 0) ? '0 : py;
    cx1 = (px + sw > SW) ? SW : px + sw;
    cy1 = (py + sh > SH) ? SH : py + sh;
  end

  // Cursor advance after one text pixel.
  logic signed [17:0] ncx, ncy;
  logic text_last;
  always_comb begin
    ncx = cur_x_q + 18'sd1;
    ncy = cur_y_q;
    if (ncx >= win_w_q) begin
      ncx = '0;
      ncy = cur_y_q + 18'sd1;
    end
    text_last = (sc_q == scale_q - 8'd1) && (bit_q == 3'd0) &&
                (sv_q == scale_q - 8'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
      win_x_q <= '0; win_y_q <= '0; win_w_q <= '0; win_h_q <= '0;
      cur_x_q <= '0; cur_y_q <= '0;
      gx_q <= '0; gy_q <= '0; gw_q <= '0; gh_q <= '0;
      gcol_q <= '0; grow_q <= '0;
      glevel_q <= '0; gfore_q <= '0; gback_q <= '0;
    end else begin
      // Drop the result once its transfer completes.
      if (rsp_valid_q && !rsp_stall_i) rsp_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AddrW'(1);
          if (clr_q == AddrW'(Depth - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            case (req_type_i)
              REQ_WINDOW: begin
                win_x_q <= px; win_y_q <= py; win_w_q <= sw; win_h_q <= sh;
                cur_x_q <= '0; cur_y_q <= '0;
              end
              REQ_FILL: begin
                fx_q <= cx0; fx0_q <= cx0; fy_q <= cy0;
                fx1_q <= cx1; fy1_q <= cy1;
                rowbase_q <= pix_addr(18'sd0, cy0);
                color_q <= to565(color_a_i);
                if (sw > 0 && sh > 0 && cx0 < cx1 && cy0 < cy1) state_q <= ST_FILL;
              end
              REQ_TEXT: begin
                row_q <= font_bits_i; scale_q <= scale_i;
                sv_q <= '0; sc_q <= '0; bit_q <= 3'd7;
                color_q <= to565(color_a_i); color2_q <= to565(color_b_i);
                if (scale_i != 8'd0) state_q <= ST_TEXT;
              end
              REQ_GLYPH: begin
                gx_q <= px; gy_q <= py; gw_q <= sw; gh_q <= sh;
                gcol_q <= '0; grow_q <= '0;
                glevel_q <= threshold_i;
                gfore_q <= to565(color_a_i); gback_q <= to565(color_b_i);
              end
              REQ_SAMPLE: begin
                if (samp_ok) begin
                  if (gcol_q + 18'sd1 >= gw_q) begin
                    gcol_q <= '0;
                    grow_q <= grow_q + 18'sd1;
                  end else begin
                    gcol_q <= gcol_q + 18'sd1;
                  end
                end
              end
              REQ_READ: begin
                rd_in_q <= on_screen(px, py);
                state_q <= ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_FILL: begin
          if (fx_q + 18'sd1 >= fx1_q) begin
            fx_q      <= fx0_q;
            fy_q      <= fy_q + 18'sd1;
            rowbase_q <= rowbase_q + AddrW'(SCREEN_W);
            if (fy_q + 18'sd1 >= fy1_q) state_q <= ST_IDLE;
          end else begin
            fx_q <= fx_q + 18'sd1;
          end
        end
        ST_TEXT: begin
          if (!win_ok) begin
            state_q <= ST_IDLE;
          end else begin
            cur_x_q <= ncx;
            cur_y_q <= ncy;
            if (text_last) state_q <= ST_IDLE;
            if (sc_q == scale_q - 8'd1) begin
              sc_q  <= '0;
              bit_q <= bit_q - 3'd1;
              if (bit_q == 3'd0) sv_q <= sv_q + 8'd1;
            end else begin
              sc_q <= sc_q + 8'd1;
            end
          end
        end
        ST_READ: begin
          rd_data_q   <= rdata;
          rsp_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  logic [4:0] r5, b5;
  logic [5:0] g6;
  assign r5 = rd_in_q ? rd_data_q[15:11] : '0;
  assign g6 = rd_in_q ? rd_data_q[10:5]  : '0;
  assign b5 = rd_in_q ? rd_data_q[4:0]   : '0;

  assign rsp_valid_o = rsp_valid_q;
  assign out_red_o   = {r5, r5[4:2]};
  assign out_green_o = {g6, g6[5:4]};
  assign out_blue_o  = {b5, b5[4:2]};
  assign in_range_o  = rd_in_q;

  // No request is taken during the clearing sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> req_stall_o) else $error("request during clear");

  // A read result is valid in the cycle after the read state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> rsp_valid_q) else $error("read result missing");

  // Fill sweep stays within its clip box.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FILL |-> (fx_q < fx1_q && fy_q < fy1_q))
    else $error("fill outside clip box");

endmodule
